[hw/rtl/esm_pkg.sv]
// shared constants, codes and types of the extent sector map
package esm_pkg;

  localparam int SEC_W           = 32;
  localparam int PPS_W           = 11;
  localparam int SQ_W            = 2 * PPS_W;
  localparam int CMD_W           = 2;
  localparam int STAT_W          = 3;
  localparam int LVL_W           = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;
  localparam int NUM_EXTENTS_DEF = 12;

  localparam logic [PPS_W-1:0] PPS_RESET  = 11'd128;
  localparam logic [SEC_W-1:0] NULL_RESET = 32'd0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DIRECT     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INDIRECT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_APPENDED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_APPEND_IND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NULL       = 3'd4;
  localparam logic [STAT_W-1:0] STAT_CLEARED    = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd6;

  // indirect levels
  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SINGLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_DOUBLE = 2'd2;
  localparam logic [LVL_W-1:0] LVL_TRIPLE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL = 1'd1;

  typedef struct packed {
    logic             sub;
    logic [SEC_W-1:0] a;
    logic [SEC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SEC_W-1:0] sum;
    logic             borrow;
  } alu_res_t;

  typedef struct packed {
    logic             en;
    logic [SEC_W-1:0] start;
    logic [SEC_W-1:0] len;
  } ext_wr_t;

  typedef struct packed {
    logic [PPS_W-1:0] pps;
    logic [SQ_W-1:0]  pps_sq;
    logic [SEC_W-1:0] null_code;
  } cfg_t;

endpackage

[hw/rtl/esm_alu.sv]
// shared 32-bit add/subtract unit with borrow out
module esm_alu (
  input  esm_pkg::alu_req_t req,
  output esm_pkg::alu_res_t res
);
  import esm_pkg::*;

  logic [SEC_W-1:0] b_eff;
  logic [SEC_W:0]   full;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign full  = {1'b0, req.a} + {1'b0, b_eff} + {{SEC_W{1'b0}}, req.sub};

  assign res.sum    = full[SEC_W-1:0];
  // borrow set when a < b on a subtract
  assign res.borrow = req.sub & ~full[SEC_W];

endmodule

[hw/rtl/esm_ext_mem.sv]
// extent table: start and length memories, one write and one registered read
module esm_ext_mem #(
  parameter int NUM_EXTENTS = esm_pkg::NUM_EXTENTS_DEF,
  localparam int AW = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1
) (
  input  logic                    clk,
  input  esm_pkg::ext_wr_t        wr,
  input  logic [AW-1:0]           wr_addr,
  input  logic [AW-1:0]           rd_addr,
  output logic [esm_pkg::SEC_W-1:0] rd_start,
  output logic [esm_pkg::SEC_W-1:0] rd_len
);
  import esm_pkg::*;

  logic [SEC_W-1:0] start_mem_r [NUM_EXTENTS];
  logic [SEC_W-1:0] len_mem_r   [NUM_EXTENTS];
  logic [SEC_W-1:0] rd_start_r;
  logic [SEC_W-1:0] rd_len_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_mem_r[wr_addr] <= wr.start;
      len_mem_r[wr_addr]   <= wr.len;
    end
    rd_start_r <= start_mem_r[rd_addr];
    rd_len_r   <= len_mem_r[rd_addr];
  end

  assign rd_start = rd_start_r;
  assign rd_len   = rd_len_r;

endmodule

[hw/rtl/esm_cfg.sv]
// configuration registers, with the squared pointer count kept alongside
module esm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esm_pkg::CFG_DATA_W-1:0] cfg_data,
  output esm_pkg::cfg_t                cfg
);
  import esm_pkg::*;

  logic [PPS_W-1:0] pps_r, pps_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [SEC_W-1:0] null_r, null_nxt;
  logic [SQ_W-1:0]  pps_ext;

  assign pps_ext = SQ_W'(cfg_data[PPS_W-1:0]);

  always_comb begin
    pps_nxt  = pps_r;
    sq_nxt   = sq_r;
    null_nxt = null_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PPS: begin
          pps_nxt = cfg_data[PPS_W-1:0];
          sq_nxt  = pps_ext * pps_ext;
        end
        CFG_NULL: null_nxt = cfg_data[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pps_r  <= PPS_RESET;
      sq_r   <= SQ_W'(PPS_RESET) * SQ_W'(PPS_RESET);
      null_r <= NULL_RESET;
    end else begin
      pps_r  <= pps_nxt;
      sq_r   <= sq_nxt;
      null_r <= null_nxt;
    end
  end

  assign cfg.pps       = pps_r;
  assign cfg.pps_sq    = sq_r;
  assign cfg.null_code = null_r;

endmodule

[hw/rtl/extent_sector_map_top.sv]
// Extent sector map: one command at a time, walked by a small sequencer around one shared
// add/subtract unit. A lookup walks the extents one per cycle through the single read port
// of the extent table until the hit and adds the offset to its start, or past the used
// extents splits the rest into an indirect level and slot. An append extends the last extent
// when contiguous or fills a new one, or computes the indirect slot when the table is full;
// clear, null and full cases go straight to the result. in_stall is high while a command is
// in work; a finished result waits in the output register while the next command is taken.
// The user must see that configuration is written only while idle; the block does not enforce it.
module extent_sector_map_top #(
  parameter int NUM_EXTENTS = esm_pkg::NUM_EXTENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [esm_pkg::CMD_W-1:0]     in_cmd,
  input  logic [esm_pkg::SEC_W-1:0]     in_logical_index,
  input  logic [esm_pkg::SEC_W-1:0]     in_new_sector,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [esm_pkg::STAT_W-1:0]    out_status,
  output logic [esm_pkg::SEC_W-1:0]     out_physical_sector,
  output logic [esm_pkg::LVL_W-1:0]     out_indirect_level,
  output logic [esm_pkg::SEC_W-1:0]     out_indirect_index,
  output logic [esm_pkg::SEC_W-1:0]     out_sector_count,
  input  logic                          cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import esm_pkg::*;

  localparam int AW = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1;
  localparam int CW = $clog2(NUM_EXTENTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;
  localparam logic [3:0] S_PHYS   = 4'd2;
  localparam logic [3:0] S_SPLIT1 = 4'd3;
  localparam logic [3:0] S_SPLIT2 = 4'd4;
  localparam logic [3:0] S_APND   = 4'd5;
  localparam logic [3:0] S_AIND   = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_res_t alu_res;
  ext_wr_t  wr;
  logic [AW-1:0]    wr_addr;
  logic [SEC_W-1:0] rd_start, rd_len;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [SEC_W-1:0] rem_r, rem_nxt;
  logic [SEC_W-1:0] nsec_r, nsec_nxt;
  logic             is_app_r, is_app_nxt;
  logic [SEC_W-1:0] total_r, total_nxt;
  logic [SEC_W-1:0] direct_r, direct_nxt;
  logic [SEC_W-1:0] last_start_r, last_start_nxt;
  logic [SEC_W-1:0] last_len_r, last_len_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SEC_W-1:0]  res_phys_r, res_phys_nxt;
  logic [LVL_W-1:0]  res_level_r, res_level_nxt;
  logic [SEC_W-1:0]  res_sub_r, res_sub_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [SEC_W-1:0]  out_phys_r, out_phys_nxt;
  logic [LVL_W-1:0]  out_level_r, out_level_nxt;
  logic [SEC_W-1:0]  out_sub_r, out_sub_nxt;
  logic [SEC_W-1:0]  out_count_r, out_count_nxt;

  logic [CW-1:0]     last_cnt;
  logic [STAT_W-1:0] ind_status;

  esm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  esm_ext_mem #(.NUM_EXTENTS(NUM_EXTENTS)) u_mem (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (idx_nxt),
    .rd_start (rd_start),
    .rd_len   (rd_len)
  );

  assign last_cnt   = cnt_r - 1'b1;
  assign ind_status = is_app_r ? STAT_APPEND_IND : STAT_INDIRECT;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    nsec_nxt       = nsec_r;
    is_app_nxt     = is_app_r;
    total_nxt      = total_r;
    direct_nxt     = direct_r;
    last_start_nxt = last_start_r;
    last_len_nxt   = last_len_r;
    res_status_nxt = res_status_r;
    res_phys_nxt   = res_phys_r;
    res_level_nxt  = res_level_r;
    res_sub_nxt    = res_sub_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_phys_nxt   = out_phys_r;
    out_level_nxt  = out_level_r;
    out_sub_nxt    = out_sub_r;
    out_count_nxt  = out_count_r;
    alu_req        = '0;
    wr             = '0;
    wr_addr        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // keep entry 0 on the read port so the walk starts at once
        idx_nxt = '0;
        if (in_valid) begin
          res_phys_nxt  = '0;
          res_level_nxt = LVL_NONE;
          res_sub_nxt   = '0;
          is_app_nxt    = 1'b0;
          rem_nxt       = in_logical_index;
          nsec_nxt      = in_new_sector;
          case (in_cmd)
            CMD_CLEAR: begin
              cnt_nxt        = '0;
              total_nxt      = '0;
              direct_nxt     = '0;
              last_start_nxt = '0;
              last_len_nxt   = '0;
              res_status_nxt = STAT_CLEARED;
              state_nxt      = S_DONE;
            end
            CMD_APPEND: begin
              is_app_nxt = 1'b1;
              if (in_new_sector == cfg.null_code) begin
                res_status_nxt = STAT_NULL;
                state_nxt      = S_DONE;
              end else if (total_r == '1) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_APND;
              end
            end
            default: begin
              // lookup, and the unused code behaves the same
              state_nxt = (cnt_r == '0) ? S_SPLIT1 : S_WALK;
            end
          endcase
        end
      end

      S_WALK: begin
        // rem holds the index minus the lengths walked so far
        alu_req = '{sub: 1'b1, a: rem_r, b: rd_len};
        if (alu_res.borrow) begin
          state_nxt = S_PHYS;
        end else begin
          rem_nxt = alu_res.sum;
          if (CW'(idx_r) == last_cnt) begin
            state_nxt = S_SPLIT1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_PHYS: begin
        alu_req        = '{sub: 1'b0, a: rd_start, b: rem_r};
        res_phys_nxt   = alu_res.sum;
        res_status_nxt = STAT_DIRECT;
        state_nxt      = S_DONE;
      end

      S_SPLIT1: begin
        alu_req        = '{sub: 1'b1, a: rem_r, b: SEC_W'(cfg.pps)};
        res_status_nxt = ind_status;
        if (alu_res.borrow) begin
          res_level_nxt = LVL_SINGLE;
          res_sub_nxt   = rem_r;
          state_nxt     = S_DONE;
        end else begin
          rem_nxt   = alu_res.sum;
          state_nxt = S_SPLIT2;
        end
      end

      S_SPLIT2: begin
        alu_req   = '{sub: 1'b1, a: rem_r, b: SEC_W'(cfg.pps_sq)};
        state_nxt = S_DONE;
        if (alu_res.borrow) begin
          res_level_nxt = LVL_DOUBLE;
          res_sub_nxt   = rem_r;
        end else begin
          res_level_nxt = LVL_TRIPLE;
          res_sub_nxt   = alu_res.sum;
        end
      end

      S_APND: begin
        // contiguity test against the end of the last used extent
        alu_req = '{sub: 1'b0, a: last_start_r, b: last_len_r};
        if (cnt_r != '0 && alu_res.sum == nsec_r) begin
          wr.en          = 1'b1;
          wr.start       = last_start_r;
          wr.len         = last_len_r + 1'b1;
          wr_addr        = last_cnt[AW-1:0];
          last_len_nxt   = last_len_r + 1'b1;
          direct_nxt     = direct_r + 1'b1;
          total_nxt      = total_r + 1'b1;
          res_status_nxt = STAT_APPENDED;
          state_nxt      = S_DONE;
        end else if (cnt_r < CW'(NUM_EXTENTS)) begin
          wr.en          = 1'b1;
          wr.start       = nsec_r;
          wr.len         = SEC_W'(1);
          wr_addr        = cnt_r[AW-1:0];
          last_start_nxt = nsec_r;
          last_len_nxt   = SEC_W'(1);
          cnt_nxt        = cnt_r + 1'b1;
          direct_nxt     = direct_r + 1'b1;
          total_nxt      = total_r + 1'b1;
          res_status_nxt = STAT_APPENDED;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_AIND;
        end
      end

      S_AIND: begin
        // sectors already past the direct extents
        alu_req   = '{sub: 1'b1, a: total_r, b: direct_r};
        rem_nxt   = alu_res.sum;
        total_nxt = total_r + 1'b1;
        state_nxt = S_SPLIT1;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_phys_nxt   = res_phys_r;
          out_level_nxt  = res_level_r;
          out_sub_nxt    = res_sub_r;
          out_count_nxt  = total_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      total_r      <= '0;
      direct_r     <= '0;
      last_start_r <= '0;
      last_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      total_r      <= total_nxt;
      direct_r     <= direct_nxt;
      last_start_r <= last_start_nxt;
      last_len_r   <= last_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    nsec_r       <= nsec_nxt;
    is_app_r     <= is_app_nxt;
    res_status_r <= res_status_nxt;
    res_phys_r   <= res_phys_nxt;
    res_level_r  <= res_level_nxt;
    res_sub_r    <= res_sub_nxt;
    out_status_r <= out_status_nxt;
    out_phys_r   <= out_phys_nxt;
    out_level_r  <= out_level_nxt;
    out_sub_r    <= out_sub_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_physical_sector = out_phys_r;
  assign out_indirect_level  = out_level_r;
  assign out_indirect_index  = out_sub_r;
  assign out_sector_count    = out_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_EXTENTS))
    else $error("extent fill count beyond table depth");

  a_direct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    direct_r <= total_r)
    else $error("direct sector total exceeds file sector count");

  a_level_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_level_r != LVL_NONE) ==
                     (out_status_r == STAT_INDIRECT || out_status_r == STAT_APPEND_IND)))
    else $error("indirect level does not match status");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_CLEARED) |-> out_count_r == '0)
    else $error("clear result with nonzero sector count");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not moved to output register");

endmodule

[bench/esm_checker.sv]
// beat monitor, sector map predictor and result comparison for the extent sector map
module esm_checker #(
  parameter int NUM_EXTENTS = esm_pkg::NUM_EXTENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [esm_pkg::CMD_W-1:0]     in_cmd,
  input  logic [esm_pkg::SEC_W-1:0]     in_logical_index,
  input  logic [esm_pkg::SEC_W-1:0]     in_new_sector,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [esm_pkg::STAT_W-1:0]    out_status,
  input  logic [esm_pkg::SEC_W-1:0]     out_physical_sector,
  input  logic [esm_pkg::LVL_W-1:0]     out_indirect_level,
  input  logic [esm_pkg::SEC_W-1:0]     out_indirect_index,
  input  logic [esm_pkg::SEC_W-1:0]     out_sector_count,
  input  logic                          cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import esm_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEC_W-1:0]  sector;
    logic [LVL_W-1:0]  level;
    logic [SEC_W-1:0]  slot;
    logic [SEC_W-1:0]  count;
  } map_result_t;

  logic [SEC_W-1:0] run_start [NUM_EXTENTS];
  logic [SEC_W-1:0] run_len [NUM_EXTENTS];
  logic [SEC_W-1:0] file_sectors;
  logic [PPS_W-1:0] ptrs_per_block;
  logic [SEC_W-1:0] null_code;
  map_result_t      answers_q [$];

  function automatic void locate_indirect(input logic [63:0] idx, input logic [PPS_W-1:0] pps,
                                          output logic [LVL_W-1:0] level,
                                          output logic [SEC_W-1:0] slot);
    logic [63:0] p;
    logic [63:0] sq;
    logic [63:0] rest;
    p  = 64'(pps);
    sq = p * p;
    if (idx < p) begin
      level = LVL_SINGLE;
      rest  = idx;
    end else if (idx - p < sq) begin
      level = LVL_DOUBLE;
      rest  = idx - p;
    end else begin
      level = LVL_TRIPLE;
      rest  = idx - p - sq;
    end
    slot = rest[SEC_W-1:0];
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [SEC_W-1:0] lidx,
                               input logic [SEC_W-1:0] nsec, output map_result_t r);
    int          last;
    logic [63:0] direct_total;
    logic [63:0] off;
    logic [63:0] idx;
    bit          hit;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < NUM_EXTENTS; i++) begin
        run_start[i] = '0;
        run_len[i]   = '0;
      end
      file_sectors = '0;
      r.status = STAT_CLEARED;
    end else if (cmd == CMD_APPEND) begin
      if (nsec == null_code) begin
        r.status = STAT_NULL;
      end else if (file_sectors == '1) begin
        r.status = STAT_FULL;
      end else begin
        last = -1;
        direct_total = '0;
        for (int i = 0; i < NUM_EXTENTS; i++) begin
          if (run_len[i] != '0) last = i;
          direct_total += 64'(run_len[i]);
        end
        // contiguity is checked modulo 2^32
        if (last >= 0 && nsec == SEC_W'(run_start[last] + run_len[last])) begin
          run_len[last] += 1;
          r.status = STAT_APPENDED;
        end else if (last < NUM_EXTENTS - 1) begin
          run_start[last + 1] = nsec;
          run_len[last + 1]   = 1;
          r.status = STAT_APPENDED;
        end else begin
          idx = (64'(file_sectors) >= direct_total) ? 64'(file_sectors) - direct_total : '0;
          locate_indirect(idx, ptrs_per_block, r.level, r.slot);
          r.status = STAT_APPEND_IND;
        end
        file_sectors += 1;
      end
    end else begin
      // lookup, and the undefined command behaves the same
      off = '0;
      hit = 1'b0;
      for (int i = 0; i < NUM_EXTENTS; i++) begin
        if (!hit) begin
          if (64'(lidx) < off + 64'(run_len[i])) begin
            hit = 1'b1;
            r.sector = run_start[i] + (lidx - off[SEC_W-1:0]);
          end else begin
            off += 64'(run_len[i]);
          end
        end
      end
      if (hit) begin
        r.status = STAT_DIRECT;
      end else begin
        locate_indirect(64'(lidx) - off, ptrs_per_block, r.level, r.slot);
        r.status = STAT_INDIRECT;
      end
    end
    r.count = file_sectors;
  endtask

  task automatic check_field(input string what, input logic [SEC_W-1:0] want,
                             input logic [SEC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    map_result_t want;
    map_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_EXTENTS; i++) begin
        run_start[i] = '0;
        run_len[i]   = '0;
      end
      file_sectors   = '0;
      ptrs_per_block = PPS_RESET;
      null_code      = NULL_RESET;
      answers_q.delete();
      fail_count = 0;
    end else begin
      // retire the result beat before taking a new command on the same edge
      if (out_valid && !out_stall) begin
        got = {out_status, out_physical_sector, out_indirect_level, out_indirect_index,
               out_sector_count};
        if (answers_q.size() == 0) begin
          $display("%0t: result beat with none expected, status %0d", $time, out_status);
          fail_count++;
        end else begin
          want = answers_q.pop_front();
          check_field("status", SEC_W'(want.status), SEC_W'(got.status));
          check_field("physical_sector", want.sector, got.sector);
          check_field("indirect_level", SEC_W'(want.level), SEC_W'(got.level));
          check_field("indirect_index", want.slot, got.slot);
          check_field("sector_count", want.count, got.count);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PPS: begin
            ptrs_per_block = cfg_data[PPS_W-1:0];
          end
          CFG_NULL: begin
            null_code = cfg_data[SEC_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_command(in_cmd, in_logical_index, in_new_sector, want);
        answers_q.push_back(want);
      end
    end
    pending <= answers_q.size();
  end

endmodule

[bench/testbench.sv]
// stimulus, idling and verdict for the extent sector map
module testbench;
  import esm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
  localparam int               NUM_RUNS  = NUM_EXTENTS_DEF;
  localparam int               PHASES    = 8;
  localparam int               PHASE_LEN = 235;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = CMD_LOOKUP;
  logic [SEC_W-1:0]      in_logical_index = '0;
  logic [SEC_W-1:0]      in_new_sector = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic [SEC_W-1:0]      out_physical_sector;
  logic [LVL_W-1:0]      out_indirect_level;
  logic [SEC_W-1:0]      out_indirect_index;
  logic [SEC_W-1:0]      out_sector_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PPS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    pending;

  int               tx_gap_pct = 0;
  int               rx_stall_pct = 0;
  logic [PPS_W-1:0] stim_pps = PPS_RESET;
  logic [SEC_W-1:0] stim_null = NULL_RESET;
  // rough picture of the map, only to aim the stimulus
  int               runs_used = 0;
  logic [SEC_W-1:0] run_end = '0;
  logic [SEC_W-1:0] direct_len = '0;

  always #5 clk = ~clk;

  extent_sector_map_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_logical_index    (in_logical_index),
    .in_new_sector       (in_new_sector),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_physical_sector (out_physical_sector),
    .out_indirect_level  (out_indirect_level),
    .out_indirect_index  (out_indirect_index),
    .out_sector_count    (out_sector_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  esm_checker map_watch (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_logical_index    (in_logical_index),
    .in_new_sector       (in_new_sector),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_physical_sector (out_physical_sector),
    .out_indirect_level  (out_indirect_level),
    .out_indirect_index  (out_indirect_index),
    .out_sector_count    (out_sector_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (mismatches),
    .pending             (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SEC_W-1:0] lidx,
                           input logic [SEC_W-1:0] nsec);
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_logical_index <= lidx;
    in_new_sector    <= nsec;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_CLEAR) begin
      runs_used  = 0;
      run_end    = '0;
      direct_len = '0;
    end else if (cmd == CMD_APPEND && nsec != stim_null) begin
      if (runs_used > 0 && nsec == run_end) begin
        run_end++;
        direct_len++;
      end else if (runs_used < NUM_RUNS) begin
        runs_used++;
        run_end = nsec + 1;
        direct_len++;
      end
    end
  endtask

  // drop valid and let every outstanding result come back
  task automatic hold_off;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] pps_word,
                            input logic [CFG_DATA_W-1:0] null_word);
    hold_off();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PPS;
    cfg_data  <= pps_word;
    @(negedge clk);
    cfg_index <= CFG_NULL;
    cfg_data  <= null_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    stim_pps  = pps_word[PPS_W-1:0];
    stim_null = null_word[SEC_W-1:0];
  endtask

  task automatic random_append;
    logic [SEC_W-1:0] nsec;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 35 && runs_used > 0) nsec = run_end;
    else if (pick < 43) nsec = stim_null;
    else if (pick < 50) nsec = 32'hFFFF_FFFF - $urandom_range(3);
    else nsec = $urandom;
    send_beat(CMD_APPEND, $urandom, nsec);
  endtask

  task automatic random_lookup(input logic [CMD_W-1:0] cmd);
    logic [63:0]      p;
    logic [63:0]      sq;
    logic [63:0]      delta;
    logic [SEC_W-1:0] lidx;
    p  = 64'(stim_pps);
    sq = p * p;
    case ($urandom_range(9))
      0, 1, 2: delta = '0;
      3: delta = p - 1;
      4: delta = p;
      5: delta = p + sq - 1;
      6: delta = p + sq;
      7: delta = 64'($urandom_range(32'(2 * (p + sq) + 4)));
      default: delta = 64'($urandom);
    endcase
    // a fair share of hits inside the direct extents
    if (direct_len != '0 && $urandom_range(9) < 4) lidx = $urandom_range(direct_len - 1);
    else lidx = direct_len + delta[SEC_W-1:0];
    send_beat(cmd, lidx, $urandom);
  endtask

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int left;
    int seq_len;
    int pick;
    logic [CFG_DATA_W-1:0] pps_words [PHASES];
    logic [CFG_DATA_W-1:0] null_words [PHASES];
    pps_words  = '{32'd128, 32'd1, 32'd0, (32'h0000_07FF | ($urandom & 32'hFFFF_F800)),
                   32'd1024, 32'd2, 32'd3, 32'($urandom_range(1, 2047))};
    null_words = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd0,
                   32'h8000_0000, $urandom, 32'd0, $urandom};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty map under reset settings: level boundaries, undefined command, null append
    send_beat(CMD_LOOKUP, 32'd0, 32'd0);
    send_beat(CMD_LOOKUP, 32'd128, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'd16511, 32'd0);
    send_beat(CMD_LOOKUP, 32'd16512, 32'd0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    send_beat(CMD_UNDEF, 32'd5, 32'hFFFF_FFFF);
    send_beat(CMD_APPEND, 32'hFFFF_FFFF, 32'd0);
    send_beat(CMD_APPEND, 32'd0, 32'hFFFF_FFFF);
    set_config(32'd1, 32'h5A5A_5A5A);
    // extent wrapping past the top sector, then a full table spilling to indirect
    send_beat(CMD_APPEND, 32'd0, 32'd0);
    send_beat(CMD_LOOKUP, 32'd1, 32'd0);
    send_beat(CMD_APPEND, 32'd0, 32'h5A5A_5A5A);
    for (int k = 1; k < NUM_RUNS; k++) send_beat(CMD_APPEND, 32'd0, 32'(k * 1000));
    send_beat(CMD_APPEND, 32'd0, 32'd7);
    send_beat(CMD_APPEND, 32'd0, 32'd9);
    send_beat(CMD_CLEAR, 32'd0, 32'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(pps_words[ph], null_words[ph]);
      case (ph % 4)
        0: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct = 58;
          rx_stall_pct = 0;
        end
        2: begin
          tx_gap_pct = 0;
          rx_stall_pct = 58;
        end
        default: begin
          tx_gap_pct = 32;
          rx_stall_pct = 32;
        end
      endcase
      left = PHASE_LEN;
      while (left > 0) begin
        send_beat(CMD_CLEAR, $urandom, $urandom);
        left--;
        seq_len = $urandom_range(10, 120);
        for (int k = 0; k < seq_len && left > 0; k++) begin
          if ($urandom_range(199) == 0) hold_off();
          pick = $urandom_range(99);
          if (pick < 50) random_append();
          else if (pick < 88) random_lookup(CMD_LOOKUP);
          else if (pick < 93) random_lookup(CMD_UNDEF);
          else if (pick < 95) send_beat(CMD_CLEAR, $urandom, $urandom);
          else send_beat(CMD_LOOKUP, $urandom, $urandom);
          left--;
        end
      end
    end

    hold_off();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
